// ===== hw/rtl/ptle_pkg.sv =====
// Shared types and codes of the page table LRU evictor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptle_pkg;
	typedef enum logic [2:0] {
		OP_FIND   = 3'd0,
		OP_ADD    = 3'd1,
		OP_REMOVE = 3'd2,
		OP_TOUCH  = 3'd3,
		OP_UNLINK = 3'd4,
		OP_EVICT  = 3'd5
	} op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISS    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_PINNED  = 2'd3;

	localparam int FILE_W = 8;
	localparam int PAGE_W = 16;
	localparam int MASK_W = 16;
endpackage
`default_nettype wire

// ===== hw/rtl/ptle_cell.sv =====
// One frame cell: key, valid bit and list links.
// Compares its key and rewrites its own links on commands from the sequencer.
// Depends on ptle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptle_cell #(
	parameter int LW = 5,
	parameter int IDX = 0
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire [ptle_pkg::FILE_W-1:0]     file_id,
	input  wire [ptle_pkg::PAGE_W-1:0]     page_number,
	input  wire                            wr_key,
	input  wire                            clr_valid,
	input  wire                            wr_next,
	input  wire [LW-1:0]                   next_d,
	input  wire                            wr_prev,
	input  wire [LW-1:0]                   prev_d,
	input  wire                            wr_on,
	input  wire                            on_d,
	input  wire                            hit_in,
	output logic                           hit_out,
	output logic                           match,
	output logic                           valid,
	output logic                           on,
	output logic [ptle_pkg::FILE_W-1:0]    kfile,
	output logic [ptle_pkg::PAGE_W-1:0]    kpage,
	output logic [LW-1:0]                  nxt,
	output logic [LW-1:0]                  prv
);
	logic valid_q, on_q;
	logic [ptle_pkg::FILE_W-1:0] file_q;
	logic [ptle_pkg::PAGE_W-1:0] page_q;
	logic [LW-1:0] next_q, prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			on_q    <= 1'b0;
		end else begin
			if (wr_key) valid_q <= 1'b1;
			else if (clr_valid) valid_q <= 1'b0;
			if (wr_on) on_q <= on_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_key) begin
			file_q <= file_id;
			page_q <= page_number;
		end
		if (wr_next) next_q <= next_d;
		if (wr_prev) prev_q <= prev_d;
	end

	// first match in the chain wins: pass an earlier hit on
	assign match   = valid_q && file_q == file_id && page_q == page_number && !hit_in;
	assign hit_out = hit_in || (valid_q && file_q == file_id && page_q == page_number);
	assign valid   = valid_q;
	assign on      = on_q;
	assign kfile   = file_q;
	assign kpage   = page_q;
	assign nxt     = next_q;
	assign prv     = prev_q;
endmodule
`default_nettype wire

// ===== hw/rtl/page_table_lru_evictor_top.sv =====
// Page table with LRU recency list and pinned-aware eviction.
// Each accepted word is executed and its result held until taken: touch first unlinks
// the frame and then pushes it at the head, unlink only takes it out, and evict walks the
// recency list from the tail past pinned frames, then takes out the victim. One word in
// flight at a time; the next word is accepted once the result has been taken.
// The walk over the recency list follows one link per cycle.
// Reset (arst_n low): all keys invalid, list empty; other storage undefined.
// Depends on ptle_pkg and ptle_cell.
`timescale 1ns / 1ps
`default_nettype none
module page_table_lru_evictor_top #(
	parameter int FRAMES = 16,
	// hash bucket count; every cell compares its own key, so no buckets are built
	parameter int BUCKETS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  opcode,
	input  wire  [7:0]  file_id,
	input  wire  [15:0] page_number,
	input  wire  [3:0]  frame,
	input  wire  [15:0] pinned_mask,
	input  wire  [15:0] dirty_mask,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  status,
	output logic [3:0]  frame_out,
	output logic [7:0]  victim_file_id,
	output logic [15:0] victim_page_number,
	output logic        needs_writeback
);
	localparam int LW = $clog2(FRAMES + 1);
	localparam int FW = $clog2(FRAMES);
	localparam logic [LW-1:0] NIL = LW'(FRAMES);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_TAKE, S_PUSH, S_WALK, S_OUT} state_t;
	state_t state_q;

	logic [2:0]  op_q;
	logic [7:0]  file_q;
	logic [15:0] page_q;
	logic [3:0]  frame_q;
	logic [15:0] pin_q, dirty_q;
	logic [LW-1:0] head_q, tail_q, cur_q, tgt_q;
	logic [LW:0] steps_q;

	// per-cell command bus
	logic [FRAMES-1:0] wr_key, clr_valid, wr_next, wr_prev, wr_on;
	logic [LW-1:0] next_d [FRAMES];
	logic [LW-1:0] prev_d [FRAMES];
	logic [FRAMES-1:0] on_d;
	logic [FRAMES:0] hit_chain;
	logic [FRAMES-1:0] match, valid, on;
	logic [7:0]  kfile [FRAMES];
	logic [15:0] kpage [FRAMES];
	logic [LW-1:0] nxt [FRAMES];
	logic [LW-1:0] prv [FRAMES];

	assign hit_chain[0] = 1'b0;
	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		ptle_cell #(.LW(LW), .IDX(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.file_id(file_q), .page_number(page_q),
			.wr_key(wr_key[g]), .clr_valid(clr_valid[g]),
			.wr_next(wr_next[g]), .next_d(next_d[g]),
			.wr_prev(wr_prev[g]), .prev_d(prev_d[g]),
			.wr_on(wr_on[g]), .on_d(on_d[g]),
			.hit_in(hit_chain[g]), .hit_out(hit_chain[g+1]),
			.match(match[g]), .valid(valid[g]), .on(on[g]),
			.kfile(kfile[g]), .kpage(kpage[g]), .nxt(nxt[g]), .prv(prv[g])
		);
	end

	// encode first match
	logic [FW-1:0] hit_idx;
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < FRAMES; i++)
			if (match[i]) hit_idx = FW'(i);
	end

	logic frame_ok;
	assign frame_ok = 32'(frame_q) < FRAMES;
	logic [FW-1:0] tgt_i, cur_i;
	assign tgt_i = tgt_q[FW-1:0];
	assign cur_i = cur_q[FW-1:0];
	logic cur_pinned;
	assign cur_pinned = 32'(cur_q) < 16 && pin_q[4'(cur_q)];
	logic tgt_listed;
	assign tgt_listed = on[tgt_i];
	logic [LW-1:0] tp, tn;
	assign tp = prv[tgt_i];
	assign tn = nxt[tgt_i];

	logic do_take, do_push;
	assign do_take = state_q == S_TAKE && tgt_listed;
	assign do_push = state_q == S_PUSH;

	always_comb begin
		wr_key = '0; clr_valid = '0; wr_next = '0; wr_prev = '0; wr_on = '0; on_d = '0;
		for (int i = 0; i < FRAMES; i++) begin
			next_d[i] = NIL;
			prev_d[i] = NIL;
		end
		if (state_q == S_EXEC) begin
			if (op_q == ptle_pkg::OP_ADD && frame_ok) wr_key[FW'(frame_q)] = 1'b1;
			if (op_q == ptle_pkg::OP_REMOVE && hit_chain[FRAMES]) clr_valid[hit_idx] = 1'b1;
		end
		// drop the victim's key along with its list entry
		if (state_q == S_TAKE && op_q == ptle_pkg::OP_EVICT) clr_valid[tgt_i] = 1'b1;
		if (do_take) begin
			if (tp != NIL) begin
				wr_next[tp[FW-1:0]] = 1'b1;
				next_d[tp[FW-1:0]] = tn;
			end
			if (tn != NIL) begin
				wr_prev[tn[FW-1:0]] = 1'b1;
				prev_d[tn[FW-1:0]] = tp;
			end
			wr_on[tgt_i] = 1'b1;
		end
		if (do_push) begin
			if (head_q != NIL) begin
				wr_prev[head_q[FW-1:0]] = 1'b1;
				prev_d[head_q[FW-1:0]] = tgt_q;
			end
			wr_next[tgt_i] = 1'b1;
			next_d[tgt_i] = head_q;
			wr_prev[tgt_i] = 1'b1;
			prev_d[tgt_i] = NIL;
			wr_on[tgt_i] = 1'b1;
			on_d[tgt_i] = 1'b1;
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= NIL;
			tail_q    <= NIL;
			out_valid <= 1'b0;
			op_q      <= '0;
			file_q    <= '0;
			page_q    <= '0;
			frame_q   <= '0;
			pin_q     <= '0;
			dirty_q   <= '0;
			cur_q     <= NIL;
			tgt_q     <= NIL;
			steps_q   <= '0;
			status    <= ptle_pkg::ST_OK;
			frame_out <= '0;
			victim_file_id <= '0;
			victim_page_number <= '0;
			needs_writeback <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					op_q    <= opcode;
					file_q  <= file_id;
					page_q  <= page_number;
					frame_q <= frame;
					pin_q   <= pinned_mask;
					dirty_q <= dirty_mask;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					status <= ptle_pkg::ST_OK;
					frame_out <= '0;
					victim_file_id <= '0;
					victim_page_number <= '0;
					needs_writeback <= 1'b0;
					tgt_q <= LW'(frame_q);
					state_q <= S_OUT;
					case (op_q)
						ptle_pkg::OP_FIND, ptle_pkg::OP_REMOVE: begin
							if (!hit_chain[FRAMES]) status <= ptle_pkg::ST_MISS;
							else if (op_q == ptle_pkg::OP_FIND) frame_out <= 4'(hit_idx);
						end
						ptle_pkg::OP_TOUCH, ptle_pkg::OP_UNLINK:
							if (frame_ok) state_q <= S_TAKE;
						ptle_pkg::OP_EVICT: begin
							if (head_q == NIL) status <= ptle_pkg::ST_EMPTY;
							else begin
								cur_q <= tail_q;
								steps_q <= '0;
								state_q <= S_WALK;
							end
						end
						default: ;
					endcase
				end
				S_WALK: begin
					if (cur_q == NIL || 32'(steps_q) >= FRAMES) begin
						status <= ptle_pkg::ST_PINNED;
						state_q <= S_OUT;
					end else if (cur_pinned) begin
						cur_q <= prv[cur_i];
						steps_q <= steps_q + 1'b1;
					end else begin
						frame_out <= 4'(cur_i);
						if (valid[cur_i]) begin
							victim_file_id <= kfile[cur_i];
							victim_page_number <= kpage[cur_i];
						end
						needs_writeback <= 32'(cur_q) < 16 && dirty_q[4'(cur_q)];
						tgt_q <= cur_q;
						state_q <= S_TAKE;
					end
				end
				S_TAKE: begin
					if (tgt_listed) begin
						if (tp == NIL) head_q <= tn;
						if (tn == NIL) tail_q <= tp;
					end
					state_q <= op_q == ptle_pkg::OP_TOUCH ? S_PUSH : S_OUT;
				end
				S_PUSH: begin
					if (head_q == NIL) tail_q <= tgt_q;
					head_q <= tgt_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid) out_valid <= 1'b1;
					else if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the page table LRU evictor: drives random and directed words,
// predicts each result with a behavioral copy of the page table, checks outputs.
// Depends on ptle_pkg and page_table_lru_evictor_top.
`timescale 1ns / 1ps
module tb_top;
	localparam int NF = 16;
	localparam int NIL = NF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] fid;
		logic [15:0] pg;
		logic [3:0] fr;
		logic [15:0] pin;
		logic [15:0] dirty;
	} req_t;

	typedef struct packed {
		logic [1:0] st;
		logic [3:0] fo;
		logic [7:0] vf;
		logic [15:0] vp;
		logic wb;
	} rsp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_ready = 0;
	logic [2:0] opcode = '0;
	logic [7:0] file_id = '0;
	logic [15:0] page_number = '0;
	logic [3:0] frame = '0;
	logic [15:0] pinned_mask = '0;
	logic [15:0] dirty_mask = '0;
	wire in_ready, out_valid, needs_writeback;
	wire [1:0] status;
	wire [3:0] frame_out;
	wire [7:0] victim_file_id;
	wire [15:0] victim_page_number;

	page_table_lru_evictor_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .file_id(file_id), .page_number(page_number),
		.frame(frame), .pinned_mask(pinned_mask), .dirty_mask(dirty_mask),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .frame_out(frame_out), .victim_file_id(victim_file_id),
		.victim_page_number(victim_page_number), .needs_writeback(needs_writeback)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// shadow page table
	logic pt_valid [NF];
	logic [7:0] pt_file [NF];
	logic [15:0] pt_page [NF];
	int lru_next [NF];
	int lru_prev [NF];
	logic pt_listed [NF];
	int mru_frame, lru_tail;

	req_t pending_words[$];
	rsp_t expected_rsp[$];
	int errors = 0;
	int n_sent = 0, n_checked = 0, n_pinned_err = 0;
	int send_idle = 0, recv_idle = 0;
	bit recv_hold = 0;
	bit send_pause = 0;
	longint cycles = 0;

	function automatic int lookup_key(logic [7:0] f, logic [15:0] p);
		for (int i = 0; i < NF; i++)
			if (pt_valid[i] && pt_file[i] == f && pt_page[i] == p)
				return i;
		return -1;
	endfunction

	function automatic void unlink_frame(int f);
		int p, n;
		if (!pt_listed[f])
			return;
		p = lru_prev[f];
		n = lru_next[f];
		if (p != NIL) lru_next[p] = n; else mru_frame = n;
		if (n != NIL) lru_prev[n] = p; else lru_tail = p;
		lru_next[f] = NIL;
		lru_prev[f] = NIL;
		pt_listed[f] = 0;
	endfunction

	function automatic rsp_t predict_page_op(req_t r);
		rsp_t o;
		int hit, cur, steps;
		o = '0;
		case (r.op)
			ptle_pkg::OP_FIND: begin
				hit = lookup_key(r.fid, r.pg);
				if (hit < 0) o.st = ptle_pkg::ST_MISS; else o.fo = hit[3:0];
			end
			ptle_pkg::OP_ADD: begin
				pt_file[r.fr] = r.fid;
				pt_page[r.fr] = r.pg;
				pt_valid[r.fr] = 1;
			end
			ptle_pkg::OP_REMOVE: begin
				hit = lookup_key(r.fid, r.pg);
				if (hit < 0) o.st = ptle_pkg::ST_MISS; else pt_valid[hit] = 0;
			end
			ptle_pkg::OP_TOUCH: begin
				unlink_frame(r.fr);
				lru_prev[r.fr] = NIL;
				lru_next[r.fr] = mru_frame;
				if (mru_frame != NIL) lru_prev[mru_frame] = r.fr; else lru_tail = r.fr;
				mru_frame = r.fr;
				pt_listed[r.fr] = 1;
			end
			ptle_pkg::OP_UNLINK: unlink_frame(r.fr);
			ptle_pkg::OP_EVICT: begin
				if (mru_frame == NIL) begin
					o.st = ptle_pkg::ST_EMPTY;
				end else begin
					cur = lru_tail;
					steps = 0;
					while (cur != NIL && steps < NF && r.pin[cur]) begin
						cur = lru_prev[cur];
						steps++;
					end
					if (cur == NIL || steps >= NF) begin
						o.st = ptle_pkg::ST_PINNED;
					end else begin
						o.fo = cur[3:0];
						if (pt_valid[cur]) begin
							o.vf = pt_file[cur];
							o.vp = pt_page[cur];
						end
						o.wb = r.dirty[cur];
						pt_valid[cur] = 0;
						unlink_frame(cur);
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		req_t w;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				w = pending_words.pop_front();
				expected_rsp.push_back(predict_page_op(w));
				n_sent++;
			end
			if ((!in_valid || in_ready) ) begin
				if (pending_words.size() != 0 && !send_pause
						&& $urandom_range(99) >= send_idle) begin
					w = pending_words[0];
					in_valid <= 1;
					opcode <= w.op;
					file_id <= w.fid;
					page_number <= w.pg;
					frame <= w.fr;
					pinned_mask <= w.pin;
					dirty_mask <= w.dirty;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected word st=%0d fo=%0d", $realtime,
						status, frame_out);
					errors++;
				end else begin
					e = expected_rsp.pop_front();
					n_checked++;
					if (e.st == ptle_pkg::ST_PINNED) n_pinned_err++;
					if (status !== e.st || frame_out !== e.fo || victim_file_id !== e.vf
							|| victim_page_number !== e.vp || needs_writeback !== e.wb) begin
						$display("%0t: mismatch exp st=%0d fo=%0d vf=%0h vp=%0h wb=%0d",
							$realtime, e.st, e.fo, e.vf, e.vp, e.wb);
						$display("%0t:          got st=%0d fo=%0d vf=%0h vp=%0h wb=%0d",
							$realtime, status, frame_out, victim_file_id,
							victim_page_number, needs_writeback);
						errors++;
					end
				end
			end
			out_ready <= !recv_hold && $urandom_range(99) >= recv_idle;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// small key space so finds and removes hit often
	function automatic req_t rand_word(bit full);
		req_t r;
		int k;
		k = $urandom_range(99);
		r.op = k < 12 ? ptle_pkg::OP_FIND : k < 30 ? ptle_pkg::OP_ADD :
			k < 40 ? ptle_pkg::OP_REMOVE : k < 65 ? ptle_pkg::OP_TOUCH :
			k < 75 ? ptle_pkg::OP_UNLINK : k < 97 ? ptle_pkg::OP_EVICT :
			3'($urandom_range(6, 7));
		r.fid = full ? 8'($urandom) : 8'($urandom_range(3));
		r.pg = full ? 16'($urandom) : 16'($urandom_range(3));
		r.fr = 4'($urandom);
		k = $urandom_range(3);
		r.pin = k == 0 ? 16'hffff : k == 1 ? 16'h0 : 16'($urandom & $urandom);
		r.dirty = 16'($urandom);
		return r;
	endfunction

	function automatic req_t mk(logic [2:0] op, logic [7:0] f, logic [15:0] p,
			logic [3:0] fr, logic [15:0] pin, logic [15:0] d);
		req_t r;
		r.op = op; r.fid = f; r.pg = p; r.fr = fr; r.pin = pin; r.dirty = d;
		return r;
	endfunction

	task automatic wait_drain();
		while (pending_words.size() != 0 || in_valid || expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < NF; i++) begin
			pt_valid[i] = 0; pt_listed[i] = 0; lru_next[i] = NIL; lru_prev[i] = NIL;
			pt_file[i] = 0; pt_page[i] = 0;
		end
		mru_frame = NIL;
		lru_tail = NIL;
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed: empty list, extremes, duplicates, pinned walk
		pending_words.push_back(mk(ptle_pkg::OP_EVICT, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_FIND, 8'hff, 16'hffff, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_ADD, 8'hff, 16'hffff, 15, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_ADD, 8'hff, 16'hffff, 3, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_FIND, 8'hff, 16'hffff, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_REMOVE, 8'hff, 16'hffff, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_FIND, 8'hff, 16'hffff, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_REMOVE, 8'h12, 16'h3456, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_UNLINK, 0, 0, 7, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_TOUCH, 0, 0, 15, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_TOUCH, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_TOUCH, 0, 0, 3, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_TOUCH, 0, 0, 15, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_EVICT, 0, 0, 0, 16'hffff, 16'hffff));
		pending_words.push_back(mk(ptle_pkg::OP_EVICT, 0, 0, 0, 16'h0009, 16'hffff));
		pending_words.push_back(mk(ptle_pkg::OP_UNLINK, 0, 0, 3, 0, 0));
		pending_words.push_back(mk(3'd6, 1, 1, 1, 0, 0));
		pending_words.push_back(mk(3'd7, 1, 1, 1, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_ADD, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_EVICT, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(ptle_pkg::OP_EVICT, 0, 0, 0, 0, 0));
		wait_drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 27 : ph == 1 ? 54 : 0;
			recv_idle = ph == 0 ? 54 : ph == 1 ? 27 : 0;
			for (int n = 0; n < 510; n++)
				pending_words.push_back(rand_word(n % 8 == 0));
			if (ph == 0) begin
				// hold the receiver while words keep coming
				recv_hold = 1;
				repeat (60) @(posedge clk);
				recv_hold = 0;
			end
			if (ph == 1) begin
				while (pending_words.size() > 250) @(posedge clk);
				send_pause = 1;
				while (in_valid || expected_rsp.size() != 0) @(posedge clk);
				send_pause = 0;
			end
			wait_drain();
		end
		repeat (40) @(posedge clk);

		$display("sent %0d words, checked %0d results, %0d all-pinned evicts",
			n_sent, n_checked, n_pinned_err);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
